@@ hdl/fmsf_pkg.sv @@
// Shared types, constants and byte-compare helpers for the first-match string finder.
// No dependencies; used by every module in hdl/.
package fmsf_pkg;

  localparam int BYTE_W      = 8;
  localparam int PAT_BYTES   = 16;  // bytes held by the two pattern registers
  localparam int LEN_W       = 5;   // width of the pattern length register
  localparam int OUT_OFF_W   = 32;  // width of end_offset on the result word
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int MAX_PATTERN = 16;
  localparam int OFFSET_BITS = 32;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_PAT_LEN  = 2'd0,
    REG_NOCASE   = 2'd1,
    REG_PAT_LOW  = 2'd2,
    REG_PAT_HIGH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] hay_byte;
    logic              hay_last;
  } in_word_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_OFF_W-1:0] end_offset;
  } out_word_t;

  // settings every cell sees
  typedef struct packed {
    logic [LEN_W-1:0]                    len;     // already clamped
    logic                                nocase;
    logic [PAT_BYTES-1:0][BYTE_W-1:0]    pat;
  } cell_cfg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  function automatic logic byte_ok(input logic [BYTE_W-1:0] p,
                                   input logic [BYTE_W-1:0] h,
                                   input logic              nocase);
    if (nocase) begin
      return (h == to_lower(p)) || (h == to_upper(p));
    end
    return h == p;
  endfunction

endpackage

@@ hdl/first_match_string_finder.sv @@
// Top level of the streaming first-match string finder: config registers,
// cell chain, match logic and output buffer. Depends on fmsf_pkg, fmsf_cell, fmsf_out_buf.
//
//   channel | direction | word                          | handshake
//   --------+-----------+-------------------------------+-----------------------
//   in      | input     | in_word_t  {hay_byte,hay_last}| in_valid / in_stall
//   out     | output    | out_word_t {found,end_offset} | out_valid / out_stall
//   cfg     | input     | 64-bit registers at 8*i       | APB, pready tied high
//
// Cycles: one haystack byte per clock while in_stall is low. A byte enters the cell chain
//   and is compared in the cycle it is accepted; its result word is registered in the
//   output register or skid entry. The rate is set by the combinational cell-row compare.
// Reset (rst, synchronous): clears counters, flags and buffer valids; cells start zero
//   and are also zeroed after every last byte.
// Stalls: out has an output register plus one skid entry; in_stall rises only when
//   both are full, so input keeps flowing while one result waits.
module first_match_string_finder #(
  parameter int MAX_PATTERN = fmsf_pkg::MAX_PATTERN,
  parameter int OFFSET_BITS = fmsf_pkg::OFFSET_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fmsf_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fmsf_pkg::out_word_t               out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fmsf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [fmsf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [fmsf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam logic [fmsf_pkg::LEN_W-1:0] MAX_L = fmsf_pkg::LEN_W'(MAX_PATTERN);

  // ---------------- configuration registers ----------------
  logic [fmsf_pkg::LEN_W-1:0]      pattern_length;
  logic                            case_insensitive;
  logic [fmsf_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [fmsf_pkg::CFG_DATA_W-1:0] pattern_high;
  fmsf_pkg::reg_idx_t              reg_sel;
  logic                            cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = fmsf_pkg::reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length   <= fmsf_pkg::LEN_W'(1);
      case_insensitive <= 1'b0;
      pattern_low      <= '0;
      pattern_high     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        fmsf_pkg::REG_PAT_LEN:  pattern_length   <= pwdata[fmsf_pkg::LEN_W-1:0];
        fmsf_pkg::REG_NOCASE:   case_insensitive <= pwdata[0];
        fmsf_pkg::REG_PAT_LOW:  pattern_low      <= pwdata;
        fmsf_pkg::REG_PAT_HIGH: pattern_high     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fmsf_pkg::REG_PAT_LEN:
        prdata = {{(fmsf_pkg::CFG_DATA_W-fmsf_pkg::LEN_W){1'b0}}, pattern_length};
      fmsf_pkg::REG_NOCASE:
        prdata = {{(fmsf_pkg::CFG_DATA_W-1){1'b0}}, case_insensitive};
      fmsf_pkg::REG_PAT_LOW:  prdata = pattern_low;
      fmsf_pkg::REG_PAT_HIGH: prdata = pattern_high;
      default:                prdata = '0;
    endcase
  end

  // effective length: 0 acts as 1, anything past the cell count is clipped
  fmsf_pkg::cell_cfg_t cfg;
  always_comb begin
    cfg.nocase = case_insensitive;
    cfg.pat    = {pattern_high, pattern_low};
    if (pattern_length == '0) begin
      cfg.len = fmsf_pkg::LEN_W'(1);
    end else if (pattern_length > MAX_L) begin
      cfg.len = MAX_L;
    end else begin
      cfg.len = pattern_length;
    end
  end

  // ---------------- haystack state ----------------
  logic                   in_acc;
  logic [OFFSET_BITS-1:0] seen;
  logic [OFFSET_BITS-1:0] seen_next;
  logic                   rep;        // match already reported in this haystack
  logic                   hit;
  fmsf_pkg::cell_ctrl_t   ctrl;

  assign in_acc     = in_valid && !in_stall;
  assign ctrl.shift = in_acc && !rep;  // once reported, bytes only look for the end
  assign ctrl.clear = rst || (in_acc && in_data.hay_last);

  assign seen_next = (&seen) ? seen : seen + 1'b1;  // saturating count

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      seen <= '0;
      rep  <= 1'b0;
    end else if (ctrl.shift) begin
      seen <= seen_next;
      if (hit) begin
        rep <= 1'b1;
      end
    end
  end

  // ---------------- cell chain ----------------
  logic [MAX_PATTERN-1:0][fmsf_pkg::BYTE_W-1:0] chain;  // byte entering each cell
  logic [MAX_PATTERN-1:0]                       ok;

  assign chain[0] = in_data.hay_byte;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    if (g < MAX_PATTERN - 1) begin : g_mid
      fmsf_cell #(.POS(g)) u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .cfg  (cfg),
        .d_in (chain[g]),
        .q    (chain[g+1]),
        .ok   (ok[g])
      );
    end else begin : g_end
      fmsf_cell #(.POS(g)) u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .cfg  (cfg),
        .d_in (chain[g]),
        .q    (),
        .ok   (ok[g])
      );
    end
  end

  // ---------------- match and result ----------------
  logic [fmsf_pkg::OUT_OFF_W-1:0]      off_out;
  logic                                res_valid;
  fmsf_pkg::out_word_t                 res;

  // enough bytes held and every active cell agrees
  assign hit = (&ok) && (seen_next >= OFFSET_BITS'(cfg.len));

  if (OFFSET_BITS >= fmsf_pkg::OUT_OFF_W) begin : g_off_trunc
    assign off_out = seen_next[fmsf_pkg::OUT_OFF_W-1:0];
  end else begin : g_off_ext
    assign off_out = {{(fmsf_pkg::OUT_OFF_W-OFFSET_BITS){1'b0}}, seen_next};
  end

  assign res_valid      = ctrl.shift && (hit || in_data.hay_last);
  assign res.found      = hit;
  assign res.end_offset = hit ? off_out : '0;

  fmsf_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .full      (in_stall)
  );

  // ---------------- assertions ----------------
  a_no_result_after_report: assert property (@(posedge clk) disable iff (rst)
    (in_acc && rep) |-> !res_valid)
    else $error("result produced after match already reported");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.hay_last) |=> (seen == '0 && !rep))
    else $error("haystack state not cleared after last byte");

  a_miss_zero_offset: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> (res.end_offset == '0))
    else $error("miss result carries nonzero offset");

  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

endmodule

@@ hdl/fmsf_cell.sv @@
// One window cell: checks the byte entering it against the pattern byte that lines up
// with its position, then holds that byte and passes it on. Depends on fmsf_pkg.
module fmsf_cell #(
  parameter int POS = 0
) (
  input  logic                         clk,
  input  fmsf_pkg::cell_ctrl_t         ctrl,
  input  fmsf_pkg::cell_cfg_t          cfg,
  input  logic [fmsf_pkg::BYTE_W-1:0]  d_in,
  output logic [fmsf_pkg::BYTE_W-1:0]  q,
  output logic                         ok
);

  localparam logic [fmsf_pkg::LEN_W-1:0] POS_L = fmsf_pkg::LEN_W'(POS);

  logic [fmsf_pkg::LEN_W-1:0] idx_full;
  logic [3:0]                 idx;

  // newest byte sits in cell 0, so this cell meets pattern byte len-1-POS
  assign idx_full = cfg.len - POS_L - 1'b1;
  assign idx      = idx_full[3:0];
  assign ok = (POS_L >= cfg.len) || fmsf_pkg::byte_ok(cfg.pat[idx], d_in, cfg.nocase);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= d_in;
    end
  end

endmodule

@@ hdl/fmsf_out_buf.sv @@
// Result output register with a skid entry behind it. Depends on fmsf_pkg.
module fmsf_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  fmsf_pkg::out_word_t res,
  output logic                out_valid,
  input  logic                out_stall,
  output fmsf_pkg::out_word_t out_data,
  output logic                full
);

  logic                skid_valid;
  fmsf_pkg::out_word_t skid_data;
  logic                pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        out_valid  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= res;
      end else begin
        out_data  <= res;
      end
    end else if (res_valid) begin
      skid_data <= res;
    end
  end

endmodule
